FILE: rtl/bpc_pkg.sv
package bpc_pkg;

  // field widths
  localparam int RAW_W     = 24;
  localparam int CAL_W     = 16;
  localparam int ALPHA_W   = 17;
  localparam int P_OUT_W   = 17;
  localparam int T_OUT_W   = 15;
  localparam int CFG_IDX_W = 3;

  // internal widths
  localparam int DT_W      = RAW_W + 1;   // D2 - C5*2^8
  localparam int TEMP_W    = 20;          // first-order temperature, cdeg
  localparam int COMP_W    = 42;          // OFF / SENS with corrections
  localparam int SQ_W      = 18;          // |TEMP-2000|, |TEMP+1500|
  localparam int FRAC_BITS = 8;
  localparam int FP_W      = P_OUT_W + FRAC_BITS;
  localparam int DIFF_W    = FP_W + 1;
  localparam int PROD_W    = 64;
  localparam int MPLIER_W  = RAW_W;
  localparam int MUL_CNT_W = 5;

  // shift amounts of the compensation formulas
  localparam int C5_SHIFT        = 8;
  localparam int TEMP_SHIFT      = 23;
  localparam int OFF_BASE_SHIFT  = 16;
  localparam int OFF_SHIFT       = 7;
  localparam int SENS_BASE_SHIFT = 15;
  localparam int SENS_SHIFT      = 8;
  localparam int P_SHIFT1        = 21;
  localparam int P_SHIFT2        = 15;
  localparam int FLT_SHIFT       = 16;

  localparam int T_REF       = 2000;
  localparam int T_LOW       = -1500;
  localparam int T_MIN       = -4000;
  localparam int T_MAX       = 8500;
  localparam int P_MIN       = 1000;
  localparam int P_MAX       = 120000;
  localparam int ALPHA_ONE   = 65536;
  localparam int ALPHA_RESET = 36160;
  localparam int FLT_ROUND   = 32768;
  localparam int OUT_ROUND   = 128;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SENS      = 3'd0,
    CFG_OFF       = 3'd1,
    CFG_SENS_TC   = 3'd2,
    CFG_OFF_TC    = 3'd3,
    CFG_REF_TEMP  = 3'd4,
    CFG_TEMP_GAIN = 3'd5,
    CFG_ALPHA     = 3'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_TEMP,
    ST_MUL_OFF,
    ST_MUL_SENS,
    ST_SQ_A,
    ST_SQ_B,
    ST_MUL_P,
    ST_MUL_FLT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [CAL_W-1:0]   sens_coeff;
    logic [CAL_W-1:0]   off_coeff;
    logic [CAL_W-1:0]   sens_temp_coeff;
    logic [CAL_W-1:0]   off_temp_coeff;
    logic [CAL_W-1:0]   ref_temp_coeff;
    logic [CAL_W-1:0]   temp_gain_coeff;
    logic [ALPHA_W-1:0] alpha;            // already limited to one
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic [MUL_CNT_W-1:0] nbits;
    logic [PROD_W-1:0]    mcand;
    logic [MPLIER_W-1:0]  mplier;
  } mul_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [PROD_W-1:0] prod;
  } mul_rsp_t;

endpackage

FILE: rtl/bpc_cfg_regs.sv
module bpc_cfg_regs import bpc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ALPHA_W-1:0]   cfg_data_i,
  output cfg_t                 cfg_o
);

  logic [CAL_W-1:0]   sens_q, off_q, sens_tc_q, off_tc_q, ref_temp_q, temp_gain_q;
  logic [ALPHA_W-1:0] alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_q      <= '0;
      off_q       <= '0;
      sens_tc_q   <= '0;
      off_tc_q    <= '0;
      ref_temp_q  <= '0;
      temp_gain_q <= '0;
      alpha_q     <= ALPHA_W'(ALPHA_RESET);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SENS:      sens_q      <= cfg_data_i[CAL_W-1:0];
        CFG_OFF:       off_q       <= cfg_data_i[CAL_W-1:0];
        CFG_SENS_TC:   sens_tc_q   <= cfg_data_i[CAL_W-1:0];
        CFG_OFF_TC:    off_tc_q    <= cfg_data_i[CAL_W-1:0];
        CFG_REF_TEMP:  ref_temp_q  <= cfg_data_i[CAL_W-1:0];
        CFG_TEMP_GAIN: temp_gain_q <= cfg_data_i[CAL_W-1:0];
        CFG_ALPHA:     alpha_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.sens_coeff      = sens_q;
    cfg_o.off_coeff       = off_q;
    cfg_o.sens_temp_coeff = sens_tc_q;
    cfg_o.off_temp_coeff  = off_tc_q;
    cfg_o.ref_temp_coeff  = ref_temp_q;
    cfg_o.temp_gain_coeff = temp_gain_q;
    // weight above one acts as one
    cfg_o.alpha = (alpha_q > ALPHA_W'(ALPHA_ONE)) ? ALPHA_W'(ALPHA_ONE) : alpha_q;
  end

endmodule

FILE: rtl/bpc_serial_mul.sv
module bpc_serial_mul import bpc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  // Multiplier bits shift out LSB first, one per cycle; the multiplicand
  // shifts up alongside and is added in when the bit is set.
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [MUL_CNT_W-1:0] cnt_q, cnt_d;
  logic [PROD_W-1:0]    acc_q, acc_d;
  logic [PROD_W-1:0]    mcand_q, mcand_d;
  logic [MPLIER_W-1:0]  mplier_q, mplier_d;

  always_comb begin
    busy_d   = busy_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    if (req_i.start && !busy_q) begin
      busy_d   = 1'b1;
      cnt_d    = req_i.nbits;
      acc_d    = '0;
      mcand_d  = req_i.mcand;
      mplier_d = req_i.mplier;
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        acc_d = acc_q + mcand_q;
      end
      mcand_d  = mcand_q << 1;
      mplier_d = mplier_q >> 1;
      cnt_d    = cnt_q - MUL_CNT_W'(1);
      if (cnt_q == MUL_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

endmodule

FILE: rtl/baro_pressure_compensation_lpf.sv
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i/in_ready_o   raw_pressure_i, raw_temperature_i
// out       output     out_valid_o/out_ready_i pressure_pa_o, temperature_cdeg_o
// cfg       input      cfg_we_i (no wait)      cfg_idx_i, cfg_data_i
//
// One request at a time. A result takes longer when the temperature is below 20.00 C
// and longer still below -15.00 C, where one or two extra squaring products run; the
// block returns to idle for the next request once the result is loaded. The time is set
// by the shared bit-serial multiplier, which runs the up to seven products one by one.
// Reset clears control, calibration and filter state; no clearing pass.
// A result waiting in the output register does not block the next request.
module baro_pressure_compensation_lpf import bpc_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [RAW_W-1:0]          raw_pressure_i,
  input  logic [RAW_W-1:0]          raw_temperature_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [P_OUT_W-1:0]        pressure_pa_o,
  output logic signed [T_OUT_W-1:0] temperature_cdeg_o,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ALPHA_W-1:0]        cfg_data_i
);

  cfg_t     cfg;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  state_e state_q, state_d;

  logic [RAW_W-1:0]          d1_q, d1_d;
  logic signed [DT_W-1:0]    dt_q, dt_d;
  logic signed [TEMP_W-1:0]  temp_q, temp_d;
  logic signed [COMP_W-1:0]  off_q, off_d;
  logic signed [COMP_W-1:0]  sens_q, sens_d;
  logic [FP_W-1:0]           target_q, target_d;
  logic [FP_W-1:0]           fp_q, fp_d;
  logic                      first_q, first_d;
  logic                      out_valid_q, out_valid_d;
  logic [P_OUT_W-1:0]        press_q;
  logic signed [T_OUT_W-1:0] tcd_q;

  logic                      out_load;
  logic                      in_mul;
  logic signed [PROD_W-1:0]  prod;
  logic [SQ_W-1:0]           abs_a, abs_b;
  logic signed [COMP_W-1:0]  sq, sq5, sq7, sq11;
  logic signed [COMP_W-1:0]  off_base, sens_base;
  logic signed [PROD_W-1:0]  p_full;
  logic [P_OUT_W-1:0]        p_sat;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [PROD_W-1:0]  step;
  logic [FP_W:0]             fp_round;
  logic signed [T_OUT_W-1:0] t_sat;

  bpc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  bpc_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_MUL_TEMP;
      ST_MUL_TEMP: if (mul_rsp.done) state_d = ST_MUL_OFF;
      ST_MUL_OFF:  if (mul_rsp.done) state_d = ST_MUL_SENS;
      ST_MUL_SENS: begin
        if (mul_rsp.done) begin
          state_d = (temp_q < TEMP_W'(T_REF)) ? ST_SQ_A : ST_MUL_P;
        end
      end
      ST_SQ_A: begin
        if (mul_rsp.done) begin
          state_d = (temp_q < TEMP_W'(T_LOW)) ? ST_SQ_B : ST_MUL_P;
        end
      end
      ST_SQ_B:     if (mul_rsp.done) state_d = ST_MUL_P;
      ST_MUL_P:    if (mul_rsp.done) state_d = ST_MUL_FLT;
      ST_MUL_FLT:  if (mul_rsp.done) state_d = ST_OUT;
      ST_OUT:      if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // ---------------- state outputs ----------------
  assign abs_a = SQ_W'(TEMP_W'(T_REF) - temp_q);
  assign abs_b = SQ_W'(TEMP_W'(T_LOW) - temp_q);
  assign diff  = $signed({1'b0, target_q}) - $signed({1'b0, fp_q});

  always_comb begin
    in_ready_o     = 1'b0;
    in_mul         = 1'b1;
    out_load       = 1'b0;
    mul_req.nbits  = MUL_CNT_W'(CAL_W);
    mul_req.mcand  = PROD_W'(dt_q);
    mul_req.mplier = MPLIER_W'(cfg.temp_gain_coeff);
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        in_mul     = 1'b0;
      end
      ST_MUL_TEMP: ;
      ST_MUL_OFF:  mul_req.mplier = MPLIER_W'(cfg.off_temp_coeff);
      ST_MUL_SENS: mul_req.mplier = MPLIER_W'(cfg.sens_temp_coeff);
      ST_SQ_A: begin
        mul_req.nbits  = MUL_CNT_W'(SQ_W);
        mul_req.mcand  = PROD_W'(abs_a);
        mul_req.mplier = MPLIER_W'(abs_a);
      end
      ST_SQ_B: begin
        mul_req.nbits  = MUL_CNT_W'(SQ_W);
        mul_req.mcand  = PROD_W'(abs_b);
        mul_req.mplier = MPLIER_W'(abs_b);
      end
      ST_MUL_P: begin
        mul_req.nbits  = MUL_CNT_W'(RAW_W);
        mul_req.mcand  = PROD_W'(sens_q);
        mul_req.mplier = d1_q;
      end
      ST_MUL_FLT: begin
        mul_req.nbits  = MUL_CNT_W'(ALPHA_W);
        mul_req.mcand  = PROD_W'(diff);
        mul_req.mplier = MPLIER_W'(cfg.alpha);
      end
      ST_OUT: begin
        in_mul   = 1'b0;
        out_load = !out_valid_q || out_ready_i;
      end
      default: in_mul = 1'b0;
    endcase
    // launch once per product; done drops the state out of this one
    mul_req.start = in_mul && !mul_rsp.busy && !mul_rsp.done;
  end

  // ---------------- datapath ----------------
  assign prod      = $signed(mul_rsp.prod);
  assign off_base  = COMP_W'(cfg.off_coeff) << OFF_BASE_SHIFT;
  assign sens_base = COMP_W'(cfg.sens_coeff) << SENS_BASE_SHIFT;
  assign sq        = COMP_W'(prod);
  assign sq5       = sq + (sq <<< 2);
  assign sq7       = (sq <<< 3) - sq;
  assign sq11      = (sq <<< 3) + (sq <<< 1) + sq;
  assign p_full    = ((prod >>> P_SHIFT1) - PROD_W'(off_q)) >>> P_SHIFT2;
  assign step      = (prod + PROD_W'(FLT_ROUND)) >>> FLT_SHIFT;

  always_comb begin
    if (p_full < PROD_W'(P_MIN)) begin
      p_sat = P_OUT_W'(P_MIN);
    end else if (p_full > PROD_W'(P_MAX)) begin
      p_sat = P_OUT_W'(P_MAX);
    end else begin
      p_sat = p_full[P_OUT_W-1:0];
    end
  end

  always_comb begin
    d1_d     = d1_q;
    dt_d     = dt_q;
    temp_d   = temp_q;
    off_d    = off_q;
    sens_d   = sens_q;
    target_d = target_q;
    fp_d     = fp_q;
    first_d  = first_q;
    if (in_valid_i && in_ready_o) begin
      d1_d = raw_pressure_i;
      dt_d = $signed({1'b0, raw_temperature_i})
           - $signed(DT_W'(cfg.ref_temp_coeff) << C5_SHIFT);
    end
    if (mul_rsp.done) begin
      unique case (state_q)
        ST_MUL_TEMP: temp_d = TEMP_W'(PROD_W'(T_REF) + (prod >>> TEMP_SHIFT));
        ST_MUL_OFF:  off_d  = off_base + COMP_W'(prod >>> OFF_SHIFT);
        ST_MUL_SENS: sens_d = sens_base + COMP_W'(prod >>> SENS_SHIFT);
        ST_SQ_A: begin
          off_d  = off_q - (sq5 >>> 1);
          sens_d = sens_q - (sq5 >>> 2);
        end
        ST_SQ_B: begin
          off_d  = off_q - sq7;
          sens_d = sens_q - (sq11 >>> 1);
        end
        ST_MUL_P: begin
          target_d = FP_W'(p_sat) << FRAC_BITS;
          if (first_q) begin
            // seed: the update that follows sees a zero difference
            fp_d    = FP_W'(p_sat) << FRAC_BITS;
            first_d = 1'b0;
          end
        end
        ST_MUL_FLT: fp_d = fp_q + FP_W'(step);
        default: ;
      endcase
    end
  end

  // ---------------- output register ----------------
  assign fp_round = (FP_W + 1)'(fp_q) + (FP_W + 1)'(OUT_ROUND);

  always_comb begin
    if (temp_q < TEMP_W'(T_MIN)) begin
      t_sat = T_OUT_W'(T_MIN);
    end else if (temp_q > TEMP_W'(T_MAX)) begin
      t_sat = T_OUT_W'(T_MAX);
    end else begin
      t_sat = temp_q[T_OUT_W-1:0];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fp_q        <= '0;
      first_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fp_q        <= fp_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d1_q     <= d1_d;
    dt_q     <= dt_d;
    temp_q   <= temp_d;
    off_q    <= off_d;
    sens_q   <= sens_d;
    target_q <= target_d;
    if (out_load) begin
      press_q <= P_OUT_W'(fp_round >> FRAC_BITS);
      tcd_q   <= t_sat;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign pressure_pa_o      = press_q;
  assign temperature_cdeg_o = tcd_q;

  // ---------------- assertions ----------------
  a_done_in_mul_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.done |-> (state_q != ST_IDLE && state_q != ST_OUT))
    else $error("multiplier finished outside a product step");

  a_idle_mul_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !mul_rsp.busy)
    else $error("multiplier busy while idle");

  a_seed_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(first_q) |-> $past(state_q) == ST_MUL_P)
    else $error("filter seeded outside the pressure step");

  a_filter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !first_q |-> (fp_q >= FP_W'(P_MIN << FRAC_BITS) && fp_q <= FP_W'(P_MAX << FRAC_BITS)))
    else $error("filter state left the pressure range");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_valid_o && pressure_pa_o >= P_OUT_W'(P_MIN)
                  && pressure_pa_o <= P_OUT_W'(P_MAX)))
    else $error("loaded result not valid or out of range");

endmodule

FILE: test/baro_pressure_compensation_lpf_tb.sv
module baro_pressure_compensation_lpf_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bpc_pkg::*;

  localparam int STALL_LIMIT  = 20000;
  localparam int RANDOM_ITEMS = 1250;
  localparam int MAX_REPORTS  = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

  // nominal calibration set, perturbed for most random phases
  localparam cfg_idx_e CAL_REGS [6] = '{CFG_SENS, CFG_OFF, CFG_SENS_TC,
                                        CFG_OFF_TC, CFG_REF_TEMP, CFG_TEMP_GAIN};
  localparam int NOMINAL_CAL [6] = '{40127, 36924, 23317, 23282, 33464, 28312};

  typedef struct packed {
    logic [P_OUT_W-1:0]        p;
    logic signed [T_OUT_W-1:0] t;
  } reading_t;

  typedef struct packed {
    logic                 wr;
    logic [CFG_IDX_W-1:0] idx;
    logic [ALPHA_W-1:0]   data;
    logic [RAW_W-1:0]     d1;
    logic [RAW_W-1:0]     d2;
    logic                 known;
    reading_t             kv;
  } step_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic [RAW_W-1:0]          raw_pressure_i;
  logic [RAW_W-1:0]          raw_temperature_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic [P_OUT_W-1:0]        pressure_pa_o;
  logic signed [T_OUT_W-1:0] temperature_cdeg_o;
  logic                      cfg_we_i;
  logic [CFG_IDX_W-1:0]      cfg_idx_i;
  logic [ALPHA_W-1:0]        cfg_data_i;

  // compensation model state
  logic [CAL_W-1:0]   cal_sens, cal_off, cal_sens_tc, cal_off_tc, cal_ref_temp, cal_temp_gain;
  logic [ALPHA_W-1:0] lpf_alpha;
  logic [FP_W-1:0]    lpf_state;
  logic               lpf_unseeded;

  reading_t pending_readings[$];
  step_t    plan[$];
  logic     typed_known;
  reading_t typed_reading;
  int       mismatches;

  baro_pressure_compensation_lpf DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .raw_pressure_i     (raw_pressure_i),
    .raw_temperature_i  (raw_temperature_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .pressure_pa_o      (pressure_pa_o),
    .temperature_cdeg_o (temperature_cdeg_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [ALPHA_W-1:0] data);
    case (idx)
      CFG_SENS:      cal_sens      = data[CAL_W-1:0];
      CFG_OFF:       cal_off       = data[CAL_W-1:0];
      CFG_SENS_TC:   cal_sens_tc   = data[CAL_W-1:0];
      CFG_OFF_TC:    cal_off_tc    = data[CAL_W-1:0];
      CFG_REF_TEMP:  cal_ref_temp  = data[CAL_W-1:0];
      CFG_TEMP_GAIN: cal_temp_gain = data[CAL_W-1:0];
      CFG_ALPHA:     lpf_alpha     = data;
      default: ;
    endcase
  endfunction

  // full compensation plus filter step; advances the filter state
  function automatic reading_t compensate_reading(input logic [RAW_W-1:0] d1,
                                                  input logic [RAW_W-1:0] d2);
    longint dt, temp, off, sens, dev, sq, off2, sens2, pa, target, delta, weight, acc;
    reading_t r;
    dt   = longint'(d2) - longint'(cal_ref_temp) * 256;
    temp = 2000 + ((dt * longint'(cal_temp_gain)) >>> 23);
    off  = longint'(cal_off) * 65536 + ((longint'(cal_off_tc) * dt) >>> 7);
    sens = longint'(cal_sens) * 32768 + ((longint'(cal_sens_tc) * dt) >>> 8);
    if (temp < 2000) begin
      dev   = temp - 2000;
      sq    = dev * dev;
      off2  = (5 * sq) / 2;
      sens2 = (5 * sq) / 4;
      if (temp < -1500) begin
        dev   = temp + 1500;
        sq    = dev * dev;
        off2  = off2 + 7 * sq;
        sens2 = sens2 + (11 * sq) / 2;
      end
      off  = off - off2;
      sens = sens - sens2;
    end
    pa = (((longint'(d1) * sens) >>> 21) - off) >>> 15;
    if (pa < 1000) pa = 1000;
    else if (pa > 120000) pa = 120000;
    target = pa * 256;
    if (lpf_unseeded) begin
      lpf_state    = target[FP_W-1:0];
      lpf_unseeded = 1'b0;
    end
    if (lpf_alpha > 17'd65536) weight = 65536;
    else weight = longint'(lpf_alpha);
    delta     = target - longint'(lpf_state);
    acc       = longint'(lpf_state) + ((weight * delta + 32768) >>> 16);
    lpf_state = acc[FP_W-1:0];
    acc       = (longint'(lpf_state) + 128) >>> 8;
    r.p       = acc[P_OUT_W-1:0];
    if (temp < -4000) temp = -4000;
    else if (temp > 8500) temp = 8500;
    r.t = temp[T_OUT_W-1:0];
    return r;
  endfunction

  // model updates and scoreboard, sampled at the rising edge
  always @(posedge clk_i) begin
    reading_t pred, got, want;
    if (!rst_ni) begin
      cal_sens      = '0;
      cal_off       = '0;
      cal_sens_tc   = '0;
      cal_off_tc    = '0;
      cal_ref_temp  = '0;
      cal_temp_gain = '0;
      lpf_alpha     = 17'd36160;
      lpf_state     = '0;
      lpf_unseeded  = 1'b1;
    end else begin
      if (cfg_we_i) apply_write(cfg_idx_i, cfg_data_i);
      if (in_valid_i && in_ready_o) begin
        pred = compensate_reading(raw_pressure_i, raw_temperature_i);
        if (typed_known) pending_readings.push_back(typed_reading);
        else pending_readings.push_back(pred);
      end
      if (out_valid_o && out_ready_i) begin
        got.p = pressure_pa_o;
        got.t = temperature_cdeg_o;
        if (pending_readings.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: pressure %0d temperature %0d", got.p, got.t);
        end else begin
          want = pending_readings.pop_front();
          if (got.p !== want.p || got.t !== want.t) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("mismatch: pressure exp %0d got %0d, temperature exp %0d got %0d",
                       want.p, got.p, want.t, got.t);
          end
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || cfg_we_i || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  // result side backpressure
  initial begin
    int run;
    logic level;
    out_ready_i = 1'b0;
    run = 0;
    level = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (run == 0) begin
        if ($urandom_range(0, 9) < 5) begin
          level = 1'b1;
          run   = $urandom_range(1, 40);
        end else begin
          level = 1'b0;
          run   = idle_len() + 1;
        end
      end
      out_ready_i <= level;
      run--;
    end
  end

  task automatic push_sample(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2,
                             input logic known, input reading_t kv);
    int gap;
    gap = idle_len();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    raw_pressure_i    <= d1;
    raw_temperature_i <= d2;
    typed_known       <= known;
    typed_reading     <= kv;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // drop the request and wait until every result is back
  task automatic drain_readings();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_readings.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ALPHA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
  endtask

  task automatic close_writes();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [ALPHA_W-1:0] data);
    step_t s;
    s = '0;
    s.wr   = 1'b1;
    s.idx  = idx;
    s.data = data;
    plan.push_back(s);
  endfunction

  function automatic void add_sample(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
    step_t s;
    s = '0;
    s.d1 = d1;
    s.d2 = d2;
    plan.push_back(s);
  endfunction

  function automatic void add_known(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2,
                                    input int p, input int t);
    step_t s;
    s = '0;
    s.d1    = d1;
    s.d2    = d2;
    s.known = 1'b1;
    s.kv.p  = p[P_OUT_W-1:0];
    s.kv.t  = t[T_OUT_W-1:0];
    plan.push_back(s);
  endfunction

  task automatic random_setup();
    int profile, i, pick;
    logic [CAL_W-1:0] word;
    logic [ALPHA_W-1:0] alpha;
    drain_readings();
    profile = $urandom_range(0, 9);
    for (i = 0; i < 6; i++) begin
      if (profile <= 5)
        word = CAL_W'(NOMINAL_CAL[i] + int'($urandom_range(0, 4000)) - 2000);
      else if (profile == 8) word = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      else word = CAL_W'($urandom);
      // now and then keep the previous value
      if ($urandom_range(0, 7) != 0)
        write_reg(CAL_REGS[i], {1'($urandom_range(0, 1)), word});
    end
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2, 3: alpha = ALPHA_W'($urandom_range(0, 65536));
      4:          alpha = 17'd65536;
      5:          alpha = ALPHA_W'($urandom_range(65537, 131071));
      6:          alpha = '0;
      7:          alpha = ALPHA_W'($urandom_range(1, 255));
      default:    alpha = 17'd36160;
    endcase
    write_reg(CFG_ALPHA, alpha);
    if ($urandom_range(0, 3) == 0) write_reg(CFG_IDX_UNUSED, ALPHA_W'($urandom));
    close_writes();
  endtask

  task automatic random_sample();
    int r, c;
    logic [RAW_W-1:0] d1, d2;
    r = $urandom_range(0, 19);
    if (r < 15) begin
      // spans both cold-correction branches and both temperature limits
      d1 = RAW_W'($urandom_range(3000000, 11000000));
      c  = int'(cal_ref_temp) * 256 + int'($urandom_range(0, 5000000)) - 2500000;
      if (c < 0) c = 0;
      else if (c > 16777215) c = 16777215;
      d2 = c[RAW_W-1:0];
    end else if (r < 18) begin
      d1 = RAW_W'($urandom);
      d2 = RAW_W'($urandom);
    end else begin
      d1 = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
      d2 = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
    end
    push_sample(d1, d2, 1'b0, '0);
  endtask

  initial begin
    int sent, n, i;
    step_t s;
    logic writing;
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    raw_pressure_i    = '0;
    raw_temperature_i = '0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = '0;
    cfg_data_i        = '0;
    typed_known       = 1'b0;
    typed_reading     = '0;
    mismatches        = 0;

    // uncalibrated: P is zero and clamps low, temperature sits at 20.00 C
    add_known(24'h000000, 24'h000000, 1000, 2000);
    add_known(24'hFFFFFF, 24'hFFFFFF, 1000, 2000);
    add_known(24'hFFFFFF, 24'h000000, 1000, 2000);
    add_known(24'h000000, 24'hFFFFFF, 1000, 2000);
    add_write(CFG_IDX_UNUSED, 17'h1FFFF);
    add_known(24'h800000, 24'h800000, 1000, 2000);
    // nominal calibration; the spare top data bit must be dropped
    add_write(CFG_SENS, 17'h10000 | 17'd40127);
    add_write(CFG_OFF, 17'd36924);
    add_write(CFG_SENS_TC, 17'd23317);
    add_write(CFG_OFF_TC, 17'd23282);
    add_write(CFG_REF_TEMP, 17'd33464);
    add_write(CFG_TEMP_GAIN, 17'd28312);
    add_sample(24'd9085466, 24'd8569150);
    add_sample(24'd9085466, 24'd7900000);
    add_sample(24'd8500000, 24'd7300000);
    add_sample(24'd8000000, 24'd6500000);
    add_sample(24'd9085466, 24'd11000000);
    add_sample(24'd0, 24'd8569150);
    // unity weight: output follows the clamped pressure directly
    add_write(CFG_ALPHA, 17'd65536);
    add_known(24'hFFFFFF, 24'd8569150, 120000, 2007);
    add_known(24'h000000, 24'd8569150, 1000, 2007);
    add_write(CFG_ALPHA, 17'h1FFFF);
    add_sample(24'd9085466, 24'd8569150);
    add_write(CFG_ALPHA, 17'd0);
    add_sample(24'hFFFFFF, 24'd8569150);
    add_write(CFG_ALPHA, 17'd1);
    add_sample(24'h000000, 24'h000000);
    add_write(CFG_ALPHA, 17'd36160);
    add_sample(24'hFFFFFF, 24'hFFFFFF);
    add_write(CFG_SENS, 17'h0FFFF);
    add_write(CFG_OFF, 17'h0FFFF);
    add_write(CFG_SENS_TC, 17'h0FFFF);
    add_write(CFG_OFF_TC, 17'h0FFFF);
    add_write(CFG_REF_TEMP, 17'h0FFFF);
    add_write(CFG_TEMP_GAIN, 17'h0FFFF);
    add_sample(24'h000000, 24'h000000);
    add_sample(24'hFFFFFF, 24'hFFFFFF);
    add_sample(24'hFFFFFF, 24'h000000);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    writing = 1'b0;
    for (i = 0; i < plan.size(); i++) begin
      s = plan[i];
      if (s.wr) begin
        if (!writing) drain_readings();
        writing = 1'b1;
        write_reg(s.idx, s.data);
      end else begin
        if (writing) close_writes();
        writing = 1'b0;
        push_sample(s.d1, s.d2, s.known, s.kv);
      end
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      random_setup();
      n = $urandom_range(20, 80);
      repeat (n) random_sample();
      sent += n;
    end

    drain_readings();
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
